// File: hdl/slvc_pkg.sv
// Shared types and constants for the serial line value classifier.
package slvc_pkg;

  localparam int MAX_LINE_DEF = 32;

  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [7:0] CHAR_LF = 8'd10;
  localparam logic [7:0] CHAR_0  = 8'd48;
  localparam logic [7:0] CHAR_9  = 8'd57;

  localparam int VALUE_W = 9;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 9'd255;
  localparam logic [VALUE_W-1:0] VALUE_CAP = 9'd256;
  localparam int PROD_W = 12;

  localparam logic [1:0] KIND_VALUE = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_DROP  = 2'd2;

  typedef enum logic {
    ST_COLLECT,
    ST_FLUSH
  } slvc_state_t;

endpackage

// File: hdl/slvc_if.sv
// Valid/ready stream interfaces for the input bytes and the result beats.
interface slvc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slvc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] data_byte;
  logic       last_of_run;

  modport source (output valid, output result_kind, output data_byte, output last_of_run,
                  input ready);
  modport sink   (input valid, input result_kind, input data_byte, input last_of_run,
                  output ready);
endinterface

// File: hdl/slvc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module slvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 31
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/serial_line_value_classifier.sv
// Top level: assembles serial bytes into lines and classifies each finished line.
// A value or drop beat is registered and valid in the cycle after its byte is accepted.
// A forwarded line passes the state, store read and output registers, then moves one beat
// per cycle while the output is accepted; input is held off while the line store is read
// out through its single read port. Other bytes are accepted whenever the output is free.
// Reset clears length, value and all handshake state and sets the digit flag; the store is not cleared.
module serial_line_value_classifier
  import slvc_pkg::*;
#(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  slvc_in_if.sink    in_bus,
  slvc_out_if.source out_bus
);

  localparam int DEPTH  = MAX_LINE - 1;
  localparam int ADDR_W = $clog2(DEPTH > 1 ? DEPTH : 2);
  localparam int LEN_W  = $clog2(MAX_LINE);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(DEPTH);

  slvc_state_t        state_r, state_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               digits_r, digits_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic [LEN_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               pend_r, pend_nxt;
  logic               pend_last_r, pend_last_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_kind_r, out_kind_nxt;
  logic [7:0]         out_data_r, out_data_nxt;
  logic               out_last_r, out_last_nxt;

  logic               in_ready;
  logic               accept;
  logic               is_term;
  logic               is_digit;
  logic               is_value;
  logic               line_empty;
  logic               line_full;
  logic               out_free;
  logic               load;
  logic               rd_en;
  logic               store_we;
  logic [7:0]         rd_data;
  logic [PROD_W-1:0]  prod;

  assign accept     = in_bus.valid && in_ready;
  assign is_term    = (in_bus.rx_byte == CHAR_CR) || (in_bus.rx_byte == CHAR_LF);
  assign is_digit   = (in_bus.rx_byte >= CHAR_0) && (in_bus.rx_byte <= CHAR_9);
  assign is_value   = digits_r && (value_r <= VALUE_MAX);
  assign line_empty = (len_r == '0);
  assign line_full  = (len_r == LEN_FULL);
  assign out_free   = !out_valid_r || out_bus.ready;
  assign load       = pend_r && out_free;
  assign store_we   = accept && !is_term && !line_full;
  assign prod       = PROD_W'(value_r) * PROD_W'(10)
                    + PROD_W'(4'(in_bus.rx_byte - CHAR_0));

  slvc_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (len_r[ADDR_W-1:0]),
    .wdata (in_bus.rx_byte),
    .re    (rd_en),
    .raddr (rd_idx_r[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_COLLECT: begin
        if (accept && is_term && !line_empty && !is_value) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (load && pend_last_r) begin
          state_nxt = ST_COLLECT;
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    unique case (state_r)
      ST_COLLECT: begin
        in_ready = out_free;
      end
      ST_FLUSH: begin
        rd_en = (rd_idx_r < len_r) && (!pend_r || load);
      end
      default: begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
      end
    endcase
  end

  // line bookkeeping and flush read pointer
  always_comb begin
    len_nxt       = len_r;
    digits_nxt    = digits_r;
    value_nxt     = value_r;
    rd_idx_nxt    = rd_idx_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    if (accept) begin
      if (is_term) begin
        if (!line_empty && is_value) begin
          len_nxt    = '0;
          digits_nxt = 1'b1;
          value_nxt  = '0;
        end
        rd_idx_nxt = '0;
        pend_nxt   = 1'b0;
      end else if (!line_full) begin
        len_nxt = len_r + LEN_W'(1);
        if (!is_digit) begin
          digits_nxt = 1'b0;
        end else if (digits_r) begin
          value_nxt = (prod > PROD_W'(VALUE_CAP)) ? VALUE_CAP : VALUE_W'(prod);
        end
      end else begin
        len_nxt    = '0;
        digits_nxt = 1'b1;
        value_nxt  = '0;
      end
    end
    if (rd_en) begin
      rd_idx_nxt    = rd_idx_r + LEN_W'(1);
      pend_nxt      = 1'b1;
      pend_last_nxt = ((rd_idx_r + LEN_W'(1)) == len_r);
    end else if (load) begin
      pend_nxt = 1'b0;
    end
    if (load && pend_last_r) begin
      len_nxt    = '0;
      digits_nxt = 1'b1;
      value_nxt  = '0;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
    priority if (accept && is_term && !line_empty && is_value) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_VALUE;
      out_data_nxt  = value_r[7:0];
      out_last_nxt  = 1'b1;
    end else if (accept && !is_term && line_full) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_DROP;
      out_data_nxt  = '0;
      out_last_nxt  = 1'b1;
    end else if (load) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_CHAR;
      out_data_nxt  = rd_data;
      out_last_nxt  = pend_last_r;
    end else begin
      out_kind_nxt  = out_kind_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      len_r       <= '0;
      digits_r    <= 1'b1;
      value_r     <= '0;
      rd_idx_r    <= '0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      digits_r    <= digits_nxt;
      value_r     <= value_nxt;
      rd_idx_r    <= rd_idx_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_bus.ready        = in_ready;
  assign out_bus.valid       = out_valid_r;
  assign out_bus.result_kind = out_kind_r;
  assign out_bus.data_byte   = out_data_r;
  assign out_bus.last_of_run = out_last_r;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_FULL)
    else $error("line length beyond store depth");

  a_value_cap: assert property (@(posedge clk) disable iff (!rst_n)
    value_r <= VALUE_CAP)
    else $error("running value above saturation");

  a_pend_flush: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == ST_FLUSH))
    else $error("pending store read outside flush");

  a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |-> !line_empty)
    else $error("flush of an empty line");
`endif

endmodule
